/* sv/pedestal_cell_averager_assert.svh */
// Assertion macros used by the cell engine of the pedestal cell averager.
`ifndef PEDESTAL_CELL_AVERAGER_ASSERT_SVH
`define PEDESTAL_CELL_AVERAGER_ASSERT_SVH
`ifndef SYNTH
`define PCA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pedestal cell averager assertion failed");
`define PCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pedestal cell averager assertion failed");
`else
`define PCA_ASSERT(label, clk, rst, prop)
`define PCA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/pca_pkg.sv */
// Shared constants, types and functions of the pedestal cell averager.
`default_nettype none
package pca_pkg;
  localparam int NUM_CHANNELS_DEF       = 8;
  localparam int NUM_WINDOWS_DEF        = 512;
  localparam int SAMPLES_PER_WINDOW_DEF = 64;
  localparam int ADC_BITS_DEF           = 12;
  localparam int COUNT_BITS_DEF         = 16;

  localparam int CHANNEL_BITS   = 3;
  localparam int WINDOW_BITS    = 9;
  localparam int SAMPLE_BITS    = 6;
  localparam int ADC_IN_BITS    = 12;
  localparam int ADC_WIDE_BITS  = 16;
  localparam int OUT_BITS       = 16;
  localparam int FRAC_BITS      = 4;
  localparam int IN_TDATA_BITS  = 32;
  localparam int OUT_TDATA_BITS = 32;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  function automatic int addr_bits(input int cells);
    return (cells > 1) ? $clog2(cells) : 1;
  endfunction
endpackage
`default_nettype wire

/* sv/pedestal_cell_averager.sv */
// Top level of the pedestal cell averager: input decode, queue and cell engine.
// After reset both stores are cleared, one cell per cycle, across all
// NUM_CHANNELS * NUM_WINDOWS * SAMPLES_PER_WINDOW cells (262144 by default) with s_axis_tready low.
// An accumulate word occupies the cell engine for a RAM read, then a write back.
// A read word of a cell with hits also waits for the bit-serial divider;
// a four-entry queue lets input words arrive while the engine is busy.
`default_nettype none
module pedestal_cell_averager import pca_pkg::*; #(
  parameter int NUM_CHANNELS       = NUM_CHANNELS_DEF,
  parameter int NUM_WINDOWS        = NUM_WINDOWS_DEF,
  parameter int SAMPLES_PER_WINDOW = SAMPLES_PER_WINDOW_DEF,
  parameter int ADC_BITS           = ADC_BITS_DEF,
  parameter int COUNT_BITS         = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata: channel[2:0], window[11:3], sample_index[17:12], adc_value[29:18]
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  // tuser: kind
  input  logic                      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // tdata: mean_value[15:0], hit_count[31:16]
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  // tuser: is_empty
  output logic                      m_axis_tuser
);
  localparam int CellBits = addr_bits(NUM_CHANNELS * NUM_WINDOWS * SAMPLES_PER_WINDOW);
  localparam int EntryW   = 2 + CellBits + ADC_BITS;

  logic              clear_done;
  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  logic [EntryW-1:0] push_entry;
  logic [EntryW-1:0] head_entry;

  pca_front #(
    .NUM_CHANNELS       (NUM_CHANNELS),
    .NUM_WINDOWS        (NUM_WINDOWS),
    .SAMPLES_PER_WINDOW (SAMPLES_PER_WINDOW),
    .ADC_BITS           (ADC_BITS)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .clear_done    (clear_done),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  pca_queue #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_entry),
    .pop       (q_pop),
    .head_data (head_entry),
    .full      (q_full),
    .empty     (q_empty)
  );

  pca_back #(
    .NUM_CHANNELS       (NUM_CHANNELS),
    .NUM_WINDOWS        (NUM_WINDOWS),
    .SAMPLES_PER_WINDOW (SAMPLES_PER_WINDOW),
    .ADC_BITS           (ADC_BITS),
    .COUNT_BITS         (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_entry       (head_entry),
    .q_pop         (q_pop),
    .clear_done    (clear_done),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );
endmodule
`default_nettype wire

/* sv/pca_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AddrBits-1:0] waddr,
  input  logic [WIDTH-1:0]    wdata,
  input  logic [AddrBits-1:0] raddr,
  output logic [WIDTH-1:0]    rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/pca_front.sv */
// Input side: decodes a word, checks the cell address and forms a queue entry.
`default_nettype none
module pca_front import pca_pkg::*; #(
  parameter int NUM_CHANNELS       = NUM_CHANNELS_DEF,
  parameter int NUM_WINDOWS        = NUM_WINDOWS_DEF,
  parameter int SAMPLES_PER_WINDOW = SAMPLES_PER_WINDOW_DEF,
  parameter int ADC_BITS           = ADC_BITS_DEF,
  localparam int CellBits = addr_bits(NUM_CHANNELS * NUM_WINDOWS * SAMPLES_PER_WINDOW),
  localparam int EntryW   = 2 + CellBits + ADC_BITS
) (
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: channel[2:0], window[11:3], sample_index[17:12], adc_value[29:18]
  input  logic [IN_TDATA_BITS-1:0] s_axis_tdata,
  // tuser: kind
  input  logic                     s_axis_tuser,
  input  logic                     clear_done,
  input  logic                     q_full,
  output logic                     q_push,
  output logic [EntryW-1:0]        q_entry
);
  logic [CHANNEL_BITS-1:0]  channel;
  logic [WINDOW_BITS-1:0]   window;
  logic [SAMPLE_BITS-1:0]   sample_index;
  logic [ADC_IN_BITS-1:0]   adc_value;
  logic [ADC_WIDE_BITS-1:0] adc_wide;
  logic                     in_range;
  logic [CellBits-1:0]      cell_addr;
  op_t                      op;

  assign channel      = s_axis_tdata[CHANNEL_BITS-1:0];
  assign window       = s_axis_tdata[CHANNEL_BITS +: WINDOW_BITS];
  assign sample_index = s_axis_tdata[CHANNEL_BITS + WINDOW_BITS +: SAMPLE_BITS];
  assign adc_value    = s_axis_tdata[CHANNEL_BITS + WINDOW_BITS + SAMPLE_BITS +: ADC_IN_BITS];
  assign adc_wide     = ADC_WIDE_BITS'(adc_value);
  assign op           = op_t'(s_axis_tuser);

  assign in_range = (32'(channel) < 32'(NUM_CHANNELS)) &&
                    (32'(window) < 32'(NUM_WINDOWS)) &&
                    (32'(sample_index) < 32'(SAMPLES_PER_WINDOW));

  assign cell_addr = CellBits'(32'(channel) * 32'(NUM_WINDOWS * SAMPLES_PER_WINDOW) +
                               32'(window) * 32'(SAMPLES_PER_WINDOW) + 32'(sample_index));

  assign s_axis_tready = clear_done && !q_full;
  assign q_push        = s_axis_tvalid && s_axis_tready;
  assign q_entry       = {op, in_range, cell_addr, adc_wide[ADC_BITS-1:0]};
endmodule
`default_nettype wire

/* sv/pca_queue.sv */
// Short first-in first-out queue between the input side and the cell engine.
`default_nettype none
module pca_queue import pca_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CntBits = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);
  logic [WIDTH-1:0]   slots [DEPTH];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [CntBits-1:0] fill;

  assign full      = (fill == CntBits'(DEPTH));
  assign empty     = (fill == '0);
  assign head_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end
endmodule
`default_nettype wire

/* sv/pca_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module pca_div #(
  parameter int DIVIDEND_BITS = 32,
  parameter int DIVISOR_BITS  = 16,
  localparam int StepBits = $clog2(DIVIDEND_BITS)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     busy,
  output logic [DIVIDEND_BITS-1:0] quotient
);
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVISOR_BITS-1:0]  dsr;
  logic [StepBits-1:0]      step;
  logic [DIVISOR_BITS:0]    rem_shift;
  logic [DIVISOR_BITS:0]    diff;
  logic                     fits;

  assign rem_shift = {rem, quotient[DIVIDEND_BITS-1]};
  assign diff      = rem_shift - {1'b0, dsr};
  assign fits      = !diff[DIVISOR_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && step == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
      step     <= StepBits'(DIVIDEND_BITS - 1);
    end else if (busy) begin
      rem      <= fits ? diff[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
      quotient <= {quotient[DIVIDEND_BITS-2:0], fits};
      step     <= step - 1'b1;
    end
  end
endmodule
`default_nettype wire

/* sv/pca_back.sv */
// Cell engine: clears the stores, updates cells and computes means for reads.
`default_nettype none
`include "pedestal_cell_averager_assert.svh"
module pca_back import pca_pkg::*; #(
  parameter int NUM_CHANNELS       = NUM_CHANNELS_DEF,
  parameter int NUM_WINDOWS        = NUM_WINDOWS_DEF,
  parameter int SAMPLES_PER_WINDOW = SAMPLES_PER_WINDOW_DEF,
  parameter int ADC_BITS           = ADC_BITS_DEF,
  parameter int COUNT_BITS         = COUNT_BITS_DEF,
  localparam int Cells    = NUM_CHANNELS * NUM_WINDOWS * SAMPLES_PER_WINDOW,
  localparam int CellBits = addr_bits(Cells),
  localparam int EntryW   = 2 + CellBits + ADC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  logic [EntryW-1:0]         q_entry,
  output logic                      q_pop,
  output logic                      clear_done,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // tdata: mean_value[15:0], hit_count[31:16]
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  // tuser: is_empty
  output logic                      m_axis_tuser
);
  localparam int SumBits = COUNT_BITS + ADC_BITS;
  localparam int QuoBits = SumBits + FRAC_BITS;

  typedef enum logic [4:0] {
    ST_CLEAR   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_FETCH   = 5'b00100,
    ST_DIVIDE  = 5'b01000,
    ST_DELIVER = 5'b10000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [CellBits-1:0] clr_addr;

  op_t                 cur_op;
  logic                cur_in_range;
  logic [CellBits-1:0] cur_addr;
  logic [ADC_BITS-1:0] cur_adc;
  logic [CellBits-1:0] head_addr;

  logic [COUNT_BITS-1:0] rd_count;
  logic [COUNT_BITS-1:0] count_rd;
  logic [SumBits-1:0]    sum_rd;
  logic [COUNT_BITS-1:0] count_eff;

  logic                  ram_we;
  logic [CellBits-1:0]   ram_waddr;
  logic [SumBits-1:0]    sum_wdata;
  logic [COUNT_BITS-1:0] count_wdata;

  logic                  div_start;
  logic                  div_busy;
  logic [QuoBits-1:0]    div_quo;

  logic                  out_valid;
  logic                  out_load;
  logic [OUT_BITS-1:0]   out_mean;
  logic [OUT_BITS-1:0]   out_hit;
  logic                  out_empty;

  assign head_addr  = q_entry[ADC_BITS +: CellBits];
  assign clear_done = (state != ST_CLEAR);
  assign q_pop      = (state == ST_IDLE) && !q_empty;
  assign count_eff  = cur_in_range ? count_rd : '0;

  assign ram_we = (state == ST_CLEAR) ||
                  ((state == ST_FETCH) && (cur_op == OP_ACCUM) && cur_in_range &&
                   (count_rd != '1));
  assign ram_waddr   = (state == ST_CLEAR) ? clr_addr : cur_addr;
  assign sum_wdata   = (state == ST_CLEAR) ? '0 : sum_rd + SumBits'(cur_adc);
  assign count_wdata = (state == ST_CLEAR) ? '0 : count_rd + 1'b1;

  assign div_start = (state == ST_FETCH) && (cur_op == OP_READ) && (count_eff != '0);
  assign out_load  = (state == ST_DELIVER) && (!out_valid || m_axis_tready);

  pca_ram #(
    .WIDTH (SumBits),
    .DEPTH (Cells)
  ) u_sum_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (sum_wdata),
    .raddr (head_addr),
    .rdata (sum_rd)
  );

  pca_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (Cells)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (count_wdata),
    .raddr (head_addr),
    .rdata (count_rd)
  );

  pca_div #(
    .DIVIDEND_BITS (QuoBits),
    .DIVISOR_BITS  (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sum_rd, {FRAC_BITS{1'b0}}}),
    .divisor  (count_rd),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == CellBits'(Cells - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (cur_op == OP_READ) begin
          state_next = (count_eff != '0) ? ST_DIVIDE : ST_DELIVER;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (!div_busy) begin
          state_next = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_op       <= op_t'(q_entry[EntryW-1]);
      cur_in_range <= q_entry[EntryW-2];
      cur_addr     <= head_addr;
      cur_adc      <= q_entry[ADC_BITS-1:0];
    end
    if (state == ST_FETCH) begin
      rd_count <= count_eff;
    end
    if (out_load) begin
      if (rd_count == '0) begin
        out_mean <= '0;
      end else if (64'(div_quo) > 64'(OUT_MAX)) begin
        out_mean <= OUT_MAX;
      end else begin
        out_mean <= div_quo[OUT_BITS-1:0];
      end
      out_hit   <= (32'(rd_count) > 32'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(rd_count);
      out_empty <= (rd_count == '0);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_hit, out_mean};
  assign m_axis_tuser  = out_empty;

  `PCA_ASSERT(a_we_states, clk, rst, ram_we |-> (state == ST_CLEAR || state == ST_FETCH))
  `PCA_ASSERT_NEXT(a_fetch_after_pop, clk, rst, q_pop, state == ST_FETCH)
  `PCA_ASSERT(a_div_idle_on_start, clk, rst, div_start |-> !div_busy)
  `PCA_ASSERT_NEXT(a_hold_result, clk, rst,
                   state == ST_DELIVER && out_valid && !m_axis_tready, state == ST_DELIVER)
  `PCA_ASSERT(a_no_word_in_clear, clk, rst, (state == ST_CLEAR) |-> !out_valid)
endmodule
`default_nettype wire
